>>> hw/rtl/fts_pkg.sv
// Shared types, character codes and default parameters for the format token scanner.
package fts_pkg;

    // Default sizing of the scanner.
    localparam int MAX_LEN_DEF   = 65536;
    localparam int MAX_DEPTH_DEF = 255;
    localparam int ID_BITS_DEF   = 32;

    // Characters with a meaning in the format string.
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Token gathering modes, one-hot.
    typedef enum logic [6:0] {
        GS_FRESH          = 7'b0000001,
        GS_GATHERING_MODE = 7'b0000010,
        GS_GATHERED_MODE  = 7'b0000100,
        GS_GATHERED_ID    = 7'b0001000,
        GS_GATHERING_DATA = 7'b0010000,
        GS_GARBAGE        = 7'b0100000,
        GS_GATHERING_ID   = 7'b1000000
    } gs_t;

    // One reported token.
    typedef struct packed {
        logic [31:0] token_id;
        logic [15:0] full_start;
        logic [16:0] full_end;
        logic [15:0] mode_start;
        logic [16:0] data_start;
        logic [15:0] data_end;
    } fts_result_t;

endpackage

>>> hw/rtl/fts_step.sv
// Next-state and token report logic for one scanned byte.
module fts_step
    import fts_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int ID_BITS   = ID_BITS_DEF,
    parameter int PW        = $clog2(MAX_LEN),
    parameter int DW        = $clog2(MAX_DEPTH + 1)
)
(
    input  logic [7:0]         ch,
    input  logic               first,
    input  logic [PW-1:0]      pos,
    input  logic [DW-1:0]      depth,
    input  logic               esc,
    input  gs_t                gs,
    input  logic [ID_BITS-1:0] id,
    input  logic [15:0]        open_off,
    input  logic [15:0]        mode_off,
    input  logic [16:0]        colon_off,
    input  logic [15:0]        close_off,
    output logic [PW-1:0]      pos_next,
    output logic [DW-1:0]      depth_next,
    output logic               esc_next,
    output gs_t                gs_next,
    output logic [ID_BITS-1:0] id_next,
    output logic [15:0]        open_next,
    output logic [15:0]        mode_next,
    output logic [16:0]        colon_next,
    output logic [15:0]        close_next,
    output logic               emit,
    output fts_result_t        result
);

    // State as seen by this byte: the first byte of a string starts from reset values.
    logic [PW-1:0]      pos_e;
    logic [DW-1:0]      depth_e;
    logic               esc_e;
    gs_t                gs_e;
    logic [ID_BITS-1:0] id_e;
    logic [15:0]        open_e;
    logic [15:0]        mode_e;
    logic [16:0]        colon_e;
    logic [15:0]        close_e;

    assign pos_e   = first ? '0 : pos;
    assign depth_e = first ? '0 : depth;
    assign esc_e   = first ? 1'b0 : esc;
    assign gs_e    = first ? GS_FRESH : gs;
    assign id_e    = first ? '0 : id;
    assign open_e  = first ? '0 : open_off;
    assign mode_e  = first ? '0 : mode_off;
    assign colon_e = first ? '0 : colon_off;
    assign close_e = first ? '0 : close_off;

    // Byte offsets in the output widths.
    logic [PW+16:0] pos_wide;
    logic [PW+16:0] pos_p1_wide;
    logic [15:0]    pos16;
    logic [16:0]    pos_p1;

    assign pos_wide    = (PW+17)'(pos_e);
    assign pos_p1_wide = pos_wide + (PW+17)'(1);
    assign pos16       = pos_wide[15:0];
    assign pos_p1      = pos_p1_wide[16:0];

    // Decimal accumulate: id * 10 + digit, with overflow past ID_BITS.
    logic                 is_digit;
    logic [3:0]           dval;
    logic [ID_BITS+3:0]   acc_wide;
    logic                 acc_ovf;
    logic [ID_BITS+31:0]  id_wide;

    assign is_digit = (ch >= 8'h30) && (ch <= 8'h39);
    assign dval     = ch[3:0];
    assign acc_wide = ((ID_BITS+4)'(id_e) << 3) + ((ID_BITS+4)'(id_e) << 1)
                    + (ID_BITS+4)'(dval);
    assign acc_ovf  = |acc_wide[ID_BITS+3:ID_BITS];
    assign id_wide  = (ID_BITS+32)'(id_e);

    // Per-byte scan rules.
    always_comb
    begin
        logic          digit_taken;
        logic [DW-1:0] depth_dec;

        pos_next    = (pos_e < PW'(MAX_LEN - 1)) ? pos_e + PW'(1) : pos_e;
        depth_next  = depth_e;
        esc_next    = esc_e;
        gs_next     = gs_e;
        id_next     = id_e;
        open_next   = open_e;
        mode_next   = mode_e;
        colon_next  = colon_e;
        close_next  = close_e;
        emit        = 1'b0;
        result      = '0;
        digit_taken = 1'b0;
        depth_dec   = (depth_e != '0) ? depth_e - DW'(1) : '0;

        // A digit run in progress consumes digits before anything else.
        if (gs_e == GS_GATHERING_ID)
        begin
            if (is_digit)
            begin
                digit_taken = 1'b1;
                if (acc_ovf)
                begin
                    id_next = '0;
                    gs_next = GS_GARBAGE;
                end
                else
                begin
                    id_next = acc_wide[ID_BITS-1:0];
                end
            end
            else
            begin
                gs_next = GS_GATHERED_ID;
            end
        end

        if (!digit_taken)
        begin
            if (esc_e)
            begin
                esc_next = 1'b0;
            end
            else if (ch == CH_BSLASH)
            begin
                esc_next = 1'b1;
            end
            else if (ch == CH_LBRACE)
            begin
                // An outermost open brace starts a new token.
                if (depth_e < DW'(MAX_DEPTH))
                begin
                    depth_next = depth_e + DW'(1);
                    if (depth_e == '0)
                    begin
                        gs_next    = GS_FRESH;
                        id_next    = '0;
                        open_next  = pos16;
                        mode_next  = '0;
                        colon_next = '0;
                        close_next = '0;
                    end
                end
            end
            else if (ch == CH_COLON && depth_e == DW'(1))
            begin
                if (gs_next == GS_FRESH || gs_next == GS_GATHERED_MODE)
                begin
                    gs_next = GS_GARBAGE;
                end
                else
                begin
                    gs_next = GS_GATHERING_DATA;
                end
                colon_next = pos_p1;
            end
            else if (ch == CH_RBRACE)
            begin
                // A close brace leaving depth zero reports the token unless it is garbage.
                depth_next = depth_dec;
                if (depth_dec == '0)
                begin
                    if (gs_next == GS_GATHERING_DATA)
                    begin
                        close_next = pos16;
                    end
                    else if (gs_next == GS_FRESH)
                    begin
                        gs_next = GS_GARBAGE;
                    end
                    if (gs_next != GS_GARBAGE)
                    begin
                        emit              = 1'b1;
                        result.token_id   = id_wide[31:0];
                        result.full_start = open_e;
                        result.full_end   = pos_p1;
                        result.mode_start = mode_e;
                        result.data_start = colon_e;
                        result.data_end   = close_next;
                    end
                end
            end
            else if (gs_next == GS_FRESH)
            begin
                if (is_digit)
                begin
                    id_next = ID_BITS'(dval);
                    gs_next = GS_GATHERING_ID;
                end
                else
                begin
                    mode_next = pos16;
                    gs_next   = GS_GATHERING_MODE;
                end
            end
        end
    end

endmodule

>>> hw/rtl/format_token_scanner_core.sv
// Top level of the format token scanner: input register, scan state and result register.
// The report of a byte in the input register is loaded into the result register on advance.
// One byte per cycle unless a report waits under stall; the scan state feedback is combinational.
// While a report waits under stall, the input register still takes one byte if it is empty.
// Reset (rst_n low, asynchronous) empties both registers and clears the scan state;
// a byte with first set restarts the scan state for a new string.
module format_token_scanner_core
    import fts_pkg::*;
#(
    parameter int MAX_LEN   = MAX_LEN_DEF,
    parameter int MAX_DEPTH = MAX_DEPTH_DEF,
    parameter int ID_BITS   = ID_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  ch,
    input  logic        first,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] token_id,
    output logic [15:0] full_start,
    output logic [16:0] full_end,
    output logic [15:0] mode_start,
    output logic [16:0] data_start,
    output logic [15:0] data_end
);

    localparam int PW = $clog2(MAX_LEN);
    localparam int DW = $clog2(MAX_DEPTH + 1);

    // Input stage.
    logic       in_vld_reg;
    logic [7:0] ch_reg;
    logic       first_reg;

    // Scan state.
    logic [PW-1:0]      pos_reg;
    logic [DW-1:0]      depth_reg;
    logic               esc_reg;
    gs_t                gs_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [15:0]        open_reg;
    logic [15:0]        mode_reg;
    logic [16:0]        colon_reg;
    logic [15:0]        close_reg;

    logic [PW-1:0]      pos_next;
    logic [DW-1:0]      depth_next;
    logic               esc_next;
    gs_t                gs_next;
    logic [ID_BITS-1:0] id_next;
    logic [15:0]        open_next;
    logic [15:0]        mode_next;
    logic [16:0]        colon_next;
    logic [15:0]        close_next;

    // Result stage.
    logic        out_vld_reg;
    fts_result_t res_reg;
    fts_result_t res_next;
    logic        emit;

    logic advance;
    logic step;

    // The input stage moves on whenever the result register is free or being drained.
    assign advance  = !out_vld_reg || !out_stall;
    assign step     = in_vld_reg && advance;
    assign in_stall = in_vld_reg && !advance;

    fts_step #(
        .MAX_LEN   (MAX_LEN),
        .MAX_DEPTH (MAX_DEPTH),
        .ID_BITS   (ID_BITS),
        .PW        (PW),
        .DW        (DW)
    ) u_step (
        .ch         (ch_reg),
        .first      (first_reg),
        .pos        (pos_reg),
        .depth      (depth_reg),
        .esc        (esc_reg),
        .gs         (gs_reg),
        .id         (id_reg),
        .open_off   (open_reg),
        .mode_off   (mode_reg),
        .colon_off  (colon_reg),
        .close_off  (close_reg),
        .pos_next   (pos_next),
        .depth_next (depth_next),
        .esc_next   (esc_next),
        .gs_next    (gs_next),
        .id_next    (id_next),
        .open_next  (open_next),
        .mode_next  (mode_next),
        .colon_next (colon_next),
        .close_next (close_next),
        .emit       (emit),
        .result     (res_next)
    );

    // Input register: loads on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            ch_reg    <= ch;
            first_reg <= first;
        end
    end

    // Scan state update, one byte per step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            depth_reg <= '0;
            esc_reg   <= 1'b0;
            gs_reg    <= GS_FRESH;
            id_reg    <= '0;
            open_reg  <= '0;
            mode_reg  <= '0;
            colon_reg <= '0;
            close_reg <= '0;
        end
        else if (step)
        begin
            pos_reg   <= pos_next;
            depth_reg <= depth_next;
            esc_reg   <= esc_next;
            gs_reg    <= gs_next;
            id_reg    <= id_next;
            open_reg  <= open_next;
            mode_reg  <= mode_next;
            colon_reg <= colon_next;
            close_reg <= close_next;
        end
    end

    // Result register: holds a report until its output transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= step && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step && emit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid  = out_vld_reg;
    assign token_id   = res_reg.token_id;
    assign full_start = res_reg.full_start;
    assign full_end   = res_reg.full_end;
    assign mode_start = res_reg.mode_start;
    assign data_start = res_reg.data_start;
    assign data_end   = res_reg.data_end;

endmodule

>>> hw/rtl/fts_checker.sv
// Port-level checker for the format token scanner and its bind to the top level.
module fts_checker
    import fts_pkg::*;
#(
    parameter int MAX_LEN = MAX_LEN_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [31:0] token_id,
    input logic [15:0] full_start,
    input logic [16:0] full_end,
    input logic [16:0] data_start,
    input logic [15:0] data_end
);

    // Offsets fit the output fields only when the string length does.
    localparam bit FULL_RANGE = (MAX_LEN <= 65536);

    // A stalled report stays presented.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("report dropped while stalled");

    // A stalled report keeps its id and its full start and end offsets.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(token_id) && $stable(full_start)
                                   && $stable(full_end))
        else $error("report changed while stalled");

    // The closing brace always lies after the opening brace.
    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !FULL_RANGE || (full_end > 17'(full_start)))
        else $error("token ends before it starts");

    // Gathered data always follows a colon that precedes the closing brace.
    a_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (data_end != 16'd0) |->
            !FULL_RANGE || ((data_start != 17'd0)
                            && (data_start <= 17'(data_end) + 17'd1)))
        else $error("data offsets out of order");

endmodule

bind format_token_scanner_core fts_checker #(
    .MAX_LEN (MAX_LEN)
) u_fts_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .token_id   (token_id),
    .full_start (full_start),
    .full_end   (full_end),
    .data_start (data_start),
    .data_end   (data_end)
);

>>> sim/format_token_scanner_core_tb.sv
// Self-checking testbench for the format token scanner core.
module format_token_scanner_core_tb;
    import fts_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ID_LIMIT = (64'd1 << ID_BITS_DEF) - 64'd1;
    localparam int          NUM_ROWS = 25;

    // One row of the directed stimulus; typed rows carry their own expected token.
    typedef struct {
        logic [7:0]  c;
        bit          f;
        bit          typed;
        bit          hit;
        fts_result_t tok;
    } scan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  ch = 8'h00;
    logic        first = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [31:0] token_id;
    logic [15:0] full_start;
    logic [16:0] full_end;
    logic [15:0] mode_start;
    logic [16:0] data_start;
    logic [15:0] data_end;

    // Scan state mirrored from the block.
    logic [16:0] pos_q;
    logic [7:0]  depth_q;
    bit          esc_q;
    gs_t         mode_q;
    logic [63:0] id_q;
    logic [15:0] open_q;
    logic [15:0] word_q;
    logic [16:0] colon_q;
    logic [15:0] close_q;

    fts_result_t expected_tokens [$];
    logic [7:0]  text_q [$];
    scan_row_t   directed_rows [NUM_ROWS];

    int errors = 0;
    int tokens_checked = 0;
    int bytes_sent = 0;
    int strings_started = 0;
    int id_overflows = 0;
    int peak_depth = 0;
    int burst_left = 0;
    int stall_mode = 0;
    int stall_left = 0;
    int cycle_count = 0;

    format_token_scanner_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .ch         (ch),
        .first      (first),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .token_id   (token_id),
        .full_start (full_start),
        .full_end   (full_end),
        .mode_start (mode_start),
        .data_start (data_start),
        .data_end   (data_end)
    );

    // Free-running clock.
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Hard limit on the run time.
    initial
    begin
        #(100_000_000);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    // Puts the mirrored scan state back to its post-reset value.
    function automatic void clear_scan();
        pos_q   = '0;
        depth_q = '0;
        esc_q   = 1'b0;
        mode_q  = GS_FRESH;
        id_q    = '0;
        open_q  = '0;
        word_q  = '0;
        colon_q = '0;
        close_q = '0;
    endfunction

    // Advances the scan state by one byte and reports the token it completes, if any.
    task automatic scan_byte(input logic [7:0] c, input bit f, output bit hit,
                             output fts_result_t tok);
        logic [16:0] at;
        logic [63:0] d;
        bit          consumed;
        if (f)
        begin
            clear_scan();
            strings_started++;
        end
        at       = pos_q;
        hit      = 1'b0;
        tok      = '0;
        consumed = 1'b0;

        // A digit run in progress swallows digits; anything else ends it.
        if (mode_q == GS_GATHERING_ID)
        begin
            if (is_digit(c))
            begin
                d = {56'd0, c} - 64'h30;
                if (id_q > (ID_LIMIT - d) / 64'd10)
                begin
                    id_q   = '0;
                    mode_q = GS_GARBAGE;
                    id_overflows++;
                end
                else
                begin
                    id_q = id_q * 64'd10 + d;
                end
                consumed = 1'b1;
            end
            else
            begin
                mode_q = GS_GATHERED_ID;
            end
        end

        if (!consumed)
        begin
            if (esc_q)
            begin
                esc_q = 1'b0;
            end
            else if (c == CH_BSLASH)
            begin
                esc_q = 1'b1;
            end
            else if (c == CH_LBRACE)
            begin
                if (depth_q < MAX_DEPTH_DEF)
                begin
                    depth_q++;
                    if (depth_q > peak_depth)
                        peak_depth = int'(depth_q);
                    if (depth_q == 8'd1)
                    begin
                        mode_q  = GS_FRESH;
                        id_q    = '0;
                        open_q  = at[15:0];
                        word_q  = '0;
                        colon_q = '0;
                        close_q = '0;
                    end
                end
            end
            else if (c == CH_COLON && depth_q == 8'd1)
            begin
                if (mode_q == GS_FRESH || mode_q == GS_GATHERED_MODE)
                    mode_q = GS_GARBAGE;
                else
                    mode_q = GS_GATHERING_DATA;
                colon_q = at + 17'd1;
            end
            else if (c == CH_RBRACE)
            begin
                if (depth_q > 8'd0)
                    depth_q--;
                // A close brace leaving depth zero reports the token unless it is garbage.
                if (depth_q == 8'd0)
                begin
                    if (mode_q == GS_GATHERING_DATA)
                        close_q = at[15:0];
                    else if (mode_q == GS_FRESH)
                        mode_q = GS_GARBAGE;
                    if (mode_q != GS_GARBAGE)
                    begin
                        hit            = 1'b1;
                        tok.token_id   = id_q[31:0];
                        tok.full_start = open_q;
                        tok.full_end   = at + 17'd1;
                        tok.mode_start = word_q;
                        tok.data_start = colon_q;
                        tok.data_end   = close_q;
                    end
                end
            end
            else if (mode_q == GS_FRESH)
            begin
                if (is_digit(c))
                begin
                    id_q   = {56'd0, c} - 64'h30;
                    mode_q = GS_GATHERING_ID;
                end
                else
                begin
                    word_q = at[15:0];
                    mode_q = GS_GATHERING_MODE;
                end
            end
        end

        if (pos_q < MAX_LEN_DEF - 1)
            pos_q++;
    endtask

    // Offers one byte in bursts with random gaps and records the expected token.
    task automatic push_byte(input logic [7:0] c, input bit f, input bit typed,
                             input bit typed_hit, input fts_result_t typed_tok);
        bit          hit;
        fts_result_t tok;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 2) == 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(200, 600)
                                                     : $urandom_range(1, 30);
        end
        ch       <= c;
        first    <= f;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
        scan_byte(c, f, hit, tok);
        if (typed)
        begin
            hit = typed_hit;
            tok = typed_tok;
        end
        if (hit)
            expected_tokens.insert(expected_tokens.size(), tok);
    endtask

    // Holds the sender until every expected token has come out.
    task automatic drain_tokens();
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic send_text(input bit new_str);
        for (int k = 0; k < text_q.size(); k++)
            push_byte(text_q[k], new_str && k == 0, 1'b0, 1'b0, '0);
    endtask

    // Appends one byte to the text being built.
    task automatic add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endtask

    task automatic add_str(input string s);
        for (int k = 0; k < s.len(); k++)
            add_byte(s[k]);
    endtask

    // Decimal ids, from single digits to runs well past the 32-bit range.
    task automatic add_digits();
        logic [63:0] near;
        near = 64'd4294967285 + 64'($urandom_range(0, 21));
        case ($urandom_range(0, 5))
            0: add_str($sformatf("%0d", $urandom_range(0, 9)));
            1: add_str($sformatf("%0d", $urandom_range(0, 99999)));
            2: add_str($sformatf("%0d", $urandom()));
            3: add_str($sformatf("%0d", near));
            4: add_str($sformatf("%0d%0d", $urandom(), $urandom()));
            default: add_str($sformatf("00%0d", $urandom_range(0, 999)));
        endcase
    endtask

    task automatic add_word(input int n);
        repeat (n) add_byte(8'(8'h61 + $urandom_range(0, 25)));
    endtask

    // Data after a colon: letters, digits, stray colons, escapes and small inner tokens.
    task automatic add_data();
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 9))
                0: add_byte(CH_COLON);
                1:
                begin
                    add_byte(CH_BSLASH);
                    add_byte(8'($urandom_range(0, 255)));
                end
                2:
                begin
                    add_byte(CH_LBRACE);
                    add_word($urandom_range(0, 3));
                    add_byte(CH_RBRACE);
                end
                3: add_byte(8'(8'h30 + $urandom_range(0, 9)));
                default: add_word(1);
            endcase
        end
    endtask

    // Random bytes, weighted toward the characters that steer the scan.
    task automatic add_noise();
        repeat ($urandom_range(1, 8))
        begin
            case ($urandom_range(0, 7))
                0, 1: add_byte(CH_RBRACE);
                2: add_byte(CH_LBRACE);
                3: add_byte(CH_COLON);
                4: add_byte(CH_BSLASH);
                default: add_byte(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // Builds one stretch of format text, mostly well-formed tokens.
    task automatic build_segment();
        text_q.delete();
        if ($urandom_range(0, 1) == 0)
            add_word($urandom_range(1, 4));
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:
            begin
                add_byte(CH_LBRACE);
                add_digits();
                add_byte(CH_RBRACE);
            end
            5, 6, 7:
            begin
                add_byte(CH_LBRACE);
                add_word($urandom_range(1, 6));
                add_byte(CH_RBRACE);
            end
            8, 9, 10, 11:
            begin
                add_byte(CH_LBRACE);
                add_digits();
                add_byte(CH_COLON);
                add_data();
                add_byte(CH_RBRACE);
            end
            12, 13:
            begin
                add_byte(CH_LBRACE);
                add_word($urandom_range(1, 4));
                add_byte(CH_COLON);
                add_data();
                add_byte(CH_RBRACE);
            end
            14, 15:
            begin
                add_byte(CH_BSLASH);
                add_byte(($urandom_range(0, 1) == 0) ? CH_LBRACE : CH_RBRACE);
                add_word($urandom_range(0, 3));
            end
            16:
            begin
                add_byte(CH_LBRACE);
                add_byte(CH_LBRACE);
                add_digits();
                add_byte(CH_RBRACE);
                add_data();
                add_byte(CH_RBRACE);
            end
            default: add_noise();
        endcase
    endtask

    // Receiver stall pattern: picks a new character each time its random hold count runs out.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 4);
            stall_left <= $urandom_range(50, 400);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 3) != 0);
            3: out_stall <= (cycle_count % 3 == 0);
            default: out_stall <= ($urandom_range(0, 7) == 0) ? ~out_stall : out_stall;
        endcase
    end

    task automatic report_mismatch(input string what);
        if (errors < 40)
            $display("[%0t] MISMATCH: %s", $realtime, what);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [63:0] got,
                               input logic [63:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Every token transfer is compared against the oldest expectation.
    always @(posedge clk)
    begin
        fts_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_tokens.size() == 0)
            begin
                report_mismatch($sformatf("unexpected token, id 0x%0h start %0d end %0d",
                                          token_id, full_start, full_end));
            end
            else
            begin
                want = expected_tokens.pop_front();
                check_field("token_id", 64'(token_id), 64'(want.token_id));
                check_field("full_start", 64'(full_start), 64'(want.full_start));
                check_field("full_end", 64'(full_end), 64'(want.full_end));
                check_field("mode_start", 64'(mode_start), 64'(want.mode_start));
                check_field("data_start", 64'(data_start), 64'(want.data_start));
                check_field("data_end", 64'(data_end), 64'(want.data_end));
                tokens_checked++;
            end
        end
    end

    // Main sequence.
    initial
    begin
        clear_scan();
        directed_rows = '{
            // Text outside braces, with the byte extremes.
            '{8'h00, 1'b1, 1'b1, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1, 1'b0, '0},
            // {7}: plain id token.
            '{CH_LBRACE, 1'b1, 1'b1, 1'b0, '0},
            '{8'h37, 1'b0, 1'b1, 1'b0, '0},
            '{CH_RBRACE, 1'b0, 1'b1, 1'b1, '{32'd7, 16'd0, 17'd3, 16'd0, 17'd0, 16'd0}},
            // {a}: mode word token.
            '{CH_LBRACE, 1'b0, 1'b1, 1'b0, '0},
            '{8'h61, 1'b0, 1'b1, 1'b0, '0},
            '{CH_RBRACE, 1'b0, 1'b1, 1'b1, '{32'd0, 16'd3, 17'd6, 16'd4, 17'd0, 16'd0}},
            // {1:x}: id with data.
            '{CH_LBRACE, 1'b0, 1'b1, 1'b0, '0},
            '{8'h31, 1'b0, 1'b1, 1'b0, '0},
            '{CH_COLON, 1'b0, 1'b1, 1'b0, '0},
            '{8'h78, 1'b0, 1'b1, 1'b0, '0},
            '{CH_RBRACE, 1'b0, 1'b1, 1'b1, '{32'd1, 16'd6, 17'd11, 16'd0, 17'd9, 16'd10}},
            // Stray close brace re-reports the stored token.
            '{CH_RBRACE, 1'b0, 1'b0, 1'b0, '0},
            // Escaped open brace, then an open brace holding a nested pair.
            '{CH_BSLASH, 1'b0, 1'b0, 1'b0, '0},
            '{CH_LBRACE, 1'b0, 1'b0, 1'b0, '0},
            '{CH_LBRACE, 1'b0, 1'b0, 1'b0, '0},
            '{CH_LBRACE, 1'b0, 1'b0, 1'b0, '0},
            '{CH_RBRACE, 1'b0, 1'b0, 1'b0, '0},
            // A colon in the fresh mode makes the token garbage.
            '{CH_COLON, 1'b0, 1'b0, 1'b0, '0},
            '{CH_RBRACE, 1'b0, 1'b1, 1'b0, '0},
            // A second colon after garbage starts data gathering.
            '{CH_LBRACE, 1'b0, 1'b0, 1'b0, '0},
            '{CH_COLON, 1'b0, 1'b0, 1'b0, '0},
            '{CH_COLON, 1'b0, 1'b0, 1'b0, '0},
            '{CH_RBRACE, 1'b0, 1'b0, 1'b0, '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        foreach (directed_rows[r])
            push_byte(directed_rows[r].c, directed_rows[r].f, directed_rows[r].typed,
                      directed_rows[r].hit, directed_rows[r].tok);
        drain_tokens();

        // Random strings of tokens, text and noise; the nesting test below adds about 1050.
        while (bytes_sent < 850)
        begin
            build_segment();
            send_text($urandom_range(0, 5) == 0);
        end

        // Nesting past the depth limit, closed back out and then overshot.
        repeat (2)
        begin
            text_q.delete();
            repeat ($urandom_range(256, 262)) add_byte(CH_LBRACE);
            add_digits();
            repeat (MAX_DEPTH_DEF) add_byte(CH_RBRACE);
            repeat ($urandom_range(1, 2)) add_byte(CH_RBRACE);
            send_text(1'b1);
        end
        drain_tokens();

        // Let the last tokens and any late report come out.
        in_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Scanned %0d bytes in %0d strings; %0d tokens checked, %0d id overflows.",
                 bytes_sent, strings_started, tokens_checked, id_overflows);
        $display("Nesting reached depth %0d under bursty input and a varying output stall.",
                 peak_depth);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
